>>> rtl/core/etpq_pkg.sv
package etpq_pkg;

  localparam int DEF_FREQ_FRAC_BITS  = 16;
  localparam int DEF_TABLE_ADDR_BITS = 8;

  localparam int LOG_FRAC_BITS   = 16;
  localparam int TONES_FRAC_BITS = 8;
  localparam int MANT_BITS       = 30;
  localparam int SCALE_ANCHOR    = 69;
  localparam int DEFAULT_BASE    = 440;
  localparam int DEFAULT_TONES   = 12;

  localparam int LOG_W   = LOG_FRAC_BITS + 1;   // log table entry, up to 1.0
  localparam int EXP_W   = MANT_BITS + 2;       // exp table entry, Q2.30 up to 2.0
  localparam int NMAG_W  = 15;                  // |scale step| after rounding
  localparam int DIV_W   = NMAG_W + LOG_FRAC_BITS + TONES_FRAC_BITS;

  typedef enum logic {
    REG_BASE_FREQUENCY   = 1'b0,
    REG_TONES_PER_OCTAVE = 1'b1
  } cfg_reg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 64'd0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/2^t) in Q0.16 by repeated squaring
  function automatic logic [31:0] log_entry(input int t, input int i);
    logic [63:0] y;
    logic [63:0] bits;
    if (i == (1 << t)) return 32'd1 << LOG_FRAC_BITS;
    y = 64'((1 << t) + i) << (MANT_BITS - t);
    bits = 64'd0;
    for (int b = 0; b < LOG_FRAC_BITS + 1; b++) begin
      y = (y * y) >> MANT_BITS;
      bits = bits << 1;
      if (y >= (64'd2 << MANT_BITS)) begin
        bits = bits | 64'd1;
        y = y >> 1;
      end
    end
    return 32'((bits + 64'd1) >> 1);
  endfunction

  // 2^(i/2^t) in Q2.30 as a product of rounded roots of two
  function automatic logic [31:0] exp_entry(input int t, input int i);
    logic [63:0] root [0:12];
    logic [63:0] e;
    if (i == (1 << t)) return 32'd1 << (MANT_BITS + 1);
    root[0] = 64'd1 << (MANT_BITS + 1);
    root[1] = isqrt64(64'd1 << (2 * MANT_BITS + 1));
    for (int k = 2; k <= t; k++) root[k] = isqrt64(root[k - 1] << MANT_BITS);
    e = 64'd1 << MANT_BITS;
    for (int j = 0; j < t; j++) begin
      if (((i >> j) & 1) != 0)
        e = (e * root[t - j] + (64'd1 << (MANT_BITS - 1))) >> MANT_BITS;
    end
    return 32'(e);
  endfunction

endpackage

>>> rtl/core/equal_temperament_pitch_quantizer.sv
// Snaps each frequency sample (signed Q16.16, magnitude used) to the nearest pitch of an
// equal-tempered scale set by base_frequency (Q16.16, register 0) and tones_per_octave
// (Q8.8, register 1), and returns that pitch in unsigned Q16.16, saturated at all ones.
// A zero sample, base or tone count gives zero. One sample is taken every cycle unless
// sample_stall is high; most of the pipe is the 39-stage restoring divider that turns
// the scale step back into octaves, one quotient bit per stage. Empty stages are filled
// even while a result waits at the output. Write the registers only while nothing is in flight.
module equal_temperament_pitch_quantizer
  import etpq_pkg::*;
#(
  parameter int FREQ_FRAC_BITS  = DEF_FREQ_FRAC_BITS,
  parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [31:0] frequency_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic        [31:0] quantized_frequency,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic        [31:0] cfg_data
);

  localparam int TAB_SIZE = (1 << TABLE_ADDR_BITS) + 1;
  localparam int IW       = TABLE_ADDR_BITS + 1;
  localparam int LRB      = 31 - TABLE_ADDR_BITS;
  localparam int ERB      = LOG_FRAC_BITS - TABLE_ADDR_BITS;
  localparam int LG_W     = 22;
  localparam int D_W      = LG_W + 1;
  localparam int SM_W     = D_W + 17;
  localparam int S_W      = SM_W + 1;
  localparam int QR_W     = 17;
  localparam int ONE_SH   = LOG_FRAC_BITS + TONES_FRAC_BITS;
  localparam int EV_W     = DIV_W + 1;
  localparam int K_W      = EV_W - LOG_FRAC_BITS;
  localparam int SH_W     = K_W + 1;

  localparam int ST_CAP  = 0;
  localparam int ST_LZC  = 1;
  localparam int ST_NORM = 2;
  localparam int ST_LTAB = 3;
  localparam int ST_LMUL = 4;
  localparam int ST_LOG  = 5;
  localparam int ST_DIFF = 6;
  localparam int ST_SMUL = 7;
  localparam int ST_SUM  = 8;
  localparam int ST_RND  = 9;
  localparam int ST_NUM  = 10;
  localparam int ST_DIV  = 11;
  localparam int ST_EVAL = ST_DIV + DIV_W;
  localparam int ST_ETAB = ST_EVAL + 1;
  localparam int ST_EMUL = ST_ETAB + 1;
  localparam int ST_MANT = ST_EMUL + 1;
  localparam int ST_PROD = ST_MANT + 1;
  localparam int ST_OUT  = ST_PROD + 1;
  localparam int NS      = ST_OUT + 1;

  localparam logic [31:0]     BASE_RESET  = 32'(64'(DEFAULT_BASE) << FREQ_FRAC_BITS);
  localparam logic [15:0]     TONES_RESET = 16'(DEFAULT_TONES << TONES_FRAC_BITS);
  localparam logic [S_W-1:0]  ANCHOR      = S_W'(SCALE_ANCHOR) << ONE_SH;

  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) if (x[i]) p = 5'(i);
    return p;
  endfunction

  function automatic logic [EXP_W-1:0] et_lo_sum(input logic [EXP_W-1:0] lo,
                                                 input logic [EXP_W+ERB-1:0] pr);
    return lo + EXP_W'(pr >> ERB);
  endfunction

  // configuration
  logic [31:0] base_frequency;
  logic [15:0] tones_per_octave;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frequency   <= BASE_RESET;
      tones_per_octave <= TONES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_FREQUENCY:   base_frequency   <= cfg_data;
        REG_TONES_PER_OCTAVE: tones_per_octave <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // constant tables
  logic [LOG_W-1:0] log_tab [TAB_SIZE];
  logic [EXP_W-1:0] exp_tab [TAB_SIZE];

  for (genvar gi = 0; gi < TAB_SIZE; gi++) begin : g_tab
    localparam logic [LOG_W-1:0] LOG_V = LOG_W'(log_entry(TABLE_ADDR_BITS, gi));
    localparam logic [EXP_W-1:0] EXP_V = EXP_W'(exp_entry(TABLE_ADDR_BITS, gi));
    assign log_tab[gi] = LOG_V;
    assign exp_tab[gi] = EXP_V;
  end

  // valid / ready along the pipe; a stage loads when it is empty or its successor moves
  logic [NS-1:0] vld;
  logic [NS-1:0] zf;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] zin;
  logic          zero0;

  assign rdy[NS] = !result_stall;
  for (genvar gs = 0; gs < NS; gs++) begin : g_rdy
    assign rdy[gs] = !vld[gs] || rdy[gs + 1];
  end

  assign zero0 = (frequency_in == 32'sd0) || (base_frequency == 32'd0) ||
                 (tones_per_octave == 16'd0);
  assign vin   = {vld[NS-2:0], sample_valid};
  assign zin   = {zf[NS-2:0], zero0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) if (rdy[i]) vld[i] <= vin[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) if (rdy[i]) zf[i] <= zin[i];
  end

  assign sample_stall = !rdy[0];
  assign result_valid = vld[ST_OUT];

  // magnitude, msb position, normalize (lane 0 sample, lane 1 base)
  logic [31:0] cap_mag;
  logic [31:0] lz_mag;
  logic [4:0]  lz_p [2];
  logic [31:0] nm   [2];
  logic [4:0]  np   [2];

  always_ff @(posedge clk) begin
    if (rdy[ST_CAP])
      cap_mag <= frequency_in[31] ? 32'd0 - 32'(frequency_in) : 32'(frequency_in);
    if (rdy[ST_LZC]) begin
      lz_mag  <= cap_mag;
      lz_p[0] <= msb_pos(cap_mag);
      lz_p[1] <= msb_pos(base_frequency);
    end
    if (rdy[ST_NORM]) begin
      nm[0] <= lz_mag << (5'd31 - lz_p[0]);
      nm[1] <= base_frequency << (5'd31 - lz_p[1]);
      np    <= lz_p;
    end
  end

  // log2 by table and interpolation
  logic [TABLE_ADDR_BITS-1:0] li    [2];
  logic [LOG_W-1:0]           l_lo  [2];
  logic [LOG_W-1:0]           l_hi  [2];
  logic [LOG_W-1:0]           lt_lo [2];
  logic [LOG_W-1:0]           lt_df [2];
  logic [LRB-1:0]             lt_r  [2];
  logic [4:0]                 lt_p  [2];
  logic [LOG_W+LRB-1:0]       lm_pr [2];
  logic [LOG_W-1:0]           lm_lo [2];
  logic [4:0]                 lm_p  [2];
  logic [LG_W-1:0]            lg    [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      li[l]   = nm[l][30 -: TABLE_ADDR_BITS];
      l_lo[l] = log_tab[IW'(li[l])];
      l_hi[l] = log_tab[IW'(li[l]) + IW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (rdy[ST_LTAB]) begin
        lt_lo[l] <= l_lo[l];
        lt_df[l] <= (l_hi[l] >= l_lo[l]) ? l_hi[l] - l_lo[l] : '0;
        lt_r[l]  <= nm[l][LRB-1:0];
        lt_p[l]  <= np[l];
      end
      if (rdy[ST_LMUL]) begin
        lm_pr[l] <= (LOG_W+LRB)'(lt_df[l]) * (LOG_W+LRB)'(lt_r[l]);
        lm_lo[l] <= lt_lo[l];
        lm_p[l]  <= lt_p[l];
      end
      if (rdy[ST_LOG])
        lg[l] <= LG_W'({lm_p[l], 16'd0}) + LG_W'(lm_lo[l]) + LG_W'(lm_pr[l] >> LRB);
    end
  end

  // scale step: n = round_away(69 + tones * dlog) - 69
  logic signed [D_W-1:0]  dl;
  logic signed [SM_W-1:0] sm;
  logic        [S_W-1:0]  s;
  logic        [S_W-1:0]  s_abs;
  logic        [QR_W-1:0] qr;
  logic                   sneg;
  logic [NMAG_W-1:0]      nabs;
  logic                   nneg;

  assign s_abs = s[S_W-1] ? S_W'(0) - s : s;

  always_ff @(posedge clk) begin
    if (rdy[ST_DIFF]) dl <= $signed({1'b0, lg[0]}) - $signed({1'b0, lg[1]});
    if (rdy[ST_SMUL]) sm <= dl * $signed({1'b0, tones_per_octave});
    if (rdy[ST_SUM])  s  <= {sm[SM_W-1], sm} + ANCHOR;
    if (rdy[ST_RND]) begin
      sneg <= s[S_W-1];
      qr   <= QR_W'((s_abs + (S_W'(1) << (ONE_SH - 1))) >> ONE_SH);
    end
    if (rdy[ST_NUM]) begin
      if (sneg) begin
        nneg <= 1'b1;
        nabs <= NMAG_W'(qr + QR_W'(SCALE_ANCHOR));
      end else if (qr < QR_W'(SCALE_ANCHOR)) begin
        nneg <= 1'b1;
        nabs <= NMAG_W'(QR_W'(SCALE_ANCHOR) - qr);
      end else begin
        nneg <= 1'b0;
        nabs <= NMAG_W'(qr - QR_W'(SCALE_ANCHOR));
      end
    end
  end

  // restoring divider |n| * 2^24 / tones, one quotient bit per stage
  logic [15:0]      dv_a   [DIV_W];
  logic [DIV_W-1:0] dv_q   [DIV_W];
  logic [DIV_W-1:0] dv_neg;

  for (genvar gj = 0; gj < DIV_W; gj++) begin : g_div
    logic [15:0]      src_a;
    logic [DIV_W-1:0] src_q;
    logic             src_neg;
    logic [16:0]      trial;
    logic             ge;

    if (gj == 0) begin : g_first
      assign src_a   = 16'd0;
      assign src_q   = {nabs, {ONE_SH{1'b0}}};
      assign src_neg = nneg;
    end else begin : g_next
      assign src_a   = dv_a[gj - 1];
      assign src_q   = dv_q[gj - 1];
      assign src_neg = dv_neg[gj - 1];
    end

    assign trial = {src_a, src_q[DIV_W-1]};
    assign ge    = trial >= {1'b0, tones_per_octave};

    always_ff @(posedge clk) begin
      if (rdy[ST_DIV + gj]) begin
        dv_a[gj]   <= ge ? 16'(trial - {1'b0, tones_per_octave}) : trial[15:0];
        dv_q[gj]   <= {src_q[DIV_W-2:0], ge};
        dv_neg[gj] <= src_neg;
      end
    end
  end

  // exponent in Q.16 octaves, floored; then 2^frac by table
  logic signed [EV_W-1:0]       ev;
  logic [TABLE_ADDR_BITS-1:0]   ei;
  logic [EXP_W-1:0]             e_lo_c;
  logic [EXP_W-1:0]             e_hi_c;
  logic [EXP_W-1:0]             et_lo;
  logic [EXP_W-1:0]             et_df;
  logic [ERB-1:0]               et_r;
  logic signed [K_W-1:0]        et_k;
  logic [EXP_W+ERB-1:0]         em_pr;
  logic [EXP_W-1:0]             em_lo;
  logic signed [K_W-1:0]        em_k;
  logic [EXP_W-1:0]             mant;
  logic signed [SH_W-1:0]       mt_sh;
  logic [63:0]                  pp;
  logic signed [SH_W-1:0]       pp_sh;

  assign ei     = ev[LOG_FRAC_BITS-1 -: TABLE_ADDR_BITS];
  assign e_lo_c = exp_tab[IW'(ei)];
  assign e_hi_c = exp_tab[IW'(ei) + IW'(1)];

  always_ff @(posedge clk) begin
    if (rdy[ST_EVAL]) begin
      if (dv_neg[DIV_W-1])
        ev <= EV_W'(0) - (EV_W'(dv_q[DIV_W-1]) + EV_W'(dv_a[DIV_W-1] != 16'd0));
      else
        ev <= EV_W'(dv_q[DIV_W-1]);
    end
    if (rdy[ST_ETAB]) begin
      et_lo <= e_lo_c;
      et_df <= (e_hi_c >= e_lo_c) ? e_hi_c - e_lo_c : '0;
      et_r  <= ev[ERB-1:0];
      et_k  <= ev[EV_W-1:LOG_FRAC_BITS];
    end
    if (rdy[ST_EMUL]) begin
      em_pr <= (EXP_W+ERB)'(et_df) * (EXP_W+ERB)'(et_r);
      em_lo <= et_lo;
      em_k  <= et_k;
    end
    if (rdy[ST_MANT]) begin
      mant  <= et_lo_sum(em_lo, em_pr);
      mt_sh <= SH_W'(em_k) - SH_W'(MANT_BITS);
    end
    if (rdy[ST_PROD]) begin
      pp    <= 64'(base_frequency) * 64'(mant);
      pp_sh <= mt_sh;
    end
  end

  // scale by 2^(k-30), round half up, saturate
  logic [95:0]     wide;
  logic [64:0]     rsum;
  logic [64:0]     rsh;
  logic [SH_W-1:0] rs;
  logic [31:0]     res;
  logic [31:0]     q_out;

  always_comb begin
    wide = '0;
    rsum = '0;
    rsh  = '0;
    rs   = '0;
    res  = '0;
    if (!pp_sh[SH_W-1]) begin
      if (pp_sh >= SH_W'(32)) begin
        res = '1;
      end else begin
        wide = {32'd0, pp} << pp_sh[4:0];
        res  = (wide[95:32] != '0) ? '1 : wide[31:0];
      end
    end else begin
      rs = SH_W'(0) - pp_sh;
      if (rs < SH_W'(64)) begin
        rsum = {1'b0, pp} + (65'd1 << (rs[5:0] - 6'd1));
        rsh  = rsum >> rs[5:0];
        res  = (rsh[64:32] != '0) ? '1 : rsh[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) q_out <= zf[ST_PROD] ? 32'd0 : res;
  end

  assign quantized_frequency = q_out;

endmodule

>>> rtl/core/etpq_checker.sv
module etpq_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic [31:0] frequency_in,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] quantized_frequency,
  input logic        cfg_write,
  input logic        cfg_index,
  input logic [31:0] cfg_data
);

  // a waiting result stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(quantized_frequency))
    else $error("stalled result changed");

  // an open output means the whole pipe moves
  a_no_stall_through: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !sample_stall)
    else $error("input stalled with output open");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result after reset");

endmodule

bind equal_temperament_pitch_quantizer etpq_checker u_etpq_checker (.*);
